### hdl/gcd_pkg.sv
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared widths, fixed-point constants and the CORDIC arctangent table
// function for the great-circle distance pipeline.
// ----------------------------------------------------------------------------
package gcd_pkg;

   localparam int CORDIC_STAGES   = 24;
   localparam int ANGLE_FRAC_BITS = 22;

   localparam int LAT_W    = 30;
   localparam int LON_W    = 31;
   localparam int DIFF_W   = 32;
   localparam int ANG_W    = 45;
   localparam int XY_W     = 34;
   localparam int ATAN2_W  = 35;
   localparam int Q_W      = 36;
   localparam int A_W      = 31;
   localparam int ROOT_W   = 31;
   localparam int SQRT_STAGES = 31;
   localparam int RADIUS_W = 23;
   localparam int DIST_W   = 29;
   localparam int CANG_W   = 43;
   localparam int CANG_LO_W = 21;
   localparam int DEG_LO_W = 29;
   localparam int DEG_HI_W = 28;
   localparam int TO_RAD_SHIFT = 22 + ANGLE_FRAC_BITS;

   localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
   localparam logic [63:0] PI_Q40_U    = (PI_Q60 + 64'd524288) >> 20;
   localparam logic [63:0] DEG2RAD_Q62 = PI_Q60 / 45;

   localparam logic signed [ANG_W-1:0] PI_Q40      = $signed(ANG_W'(PI_Q40_U));
   localparam logic signed [ANG_W-1:0] TWO_PI_Q40  = $signed(ANG_W'(PI_Q40_U << 1));
   localparam logic signed [ANG_W-1:0] HALF_PI_Q40 = $signed(ANG_W'(PI_Q40_U >> 1));

   localparam logic [DEG_LO_W-1:0] DEG2RAD_LO = DEG2RAD_Q62[DEG_LO_W-1:0];
   localparam logic [DEG_HI_W-1:0] DEG2RAD_HI = DEG2RAD_Q62[DEG_LO_W+DEG_HI_W-1:DEG_LO_W];

   localparam logic signed [XY_W-1:0] GAIN_Q30 = $signed(XY_W'(32'h26DD3B6A));
   localparam logic [A_W-1:0]         ONE_Q30  = A_W'(32'h40000000);

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(23'd6371000);
   localparam logic [DIST_W-1:0]   DIST_MAX     = {DIST_W{1'b1}};

   typedef struct packed {
      logic signed [XY_W-1:0] sine;
      logic signed [XY_W-1:0] cosine;
   } trig_type;

   // atan(2^-idx) in Q40: alternating series in Q62, then rounded
   function automatic logic signed [ANG_W-1:0] atan_q40(input int unsigned idx);
      logic signed [63:0] sum;
      logic [63:0] term;
      int unsigned k;
      int unsigned p;
      sum = 64'sd0;
      if (idx == 0) begin
         sum = $signed((PI_Q60 + 64'd2097152) >> 22);
      end else begin
         for (k = 0; k < 32; k++) begin
            p = idx * (2 * k + 1);
            if (p <= 62) begin
               term = (64'd1 << (62 - p)) / 64'(2 * k + 1);
               if (k[0]) begin
                  sum = sum - $signed(term);
               end else begin
                  sum = sum + $signed(term);
               end
            end
         end
         sum = (sum + 64'sd2097152) >>> 22;
      end
      return ANG_W'(sum);
   endfunction

endpackage

### hdl/great_circle_distance.sv
// ----------------------------------------------------------------------------
// great_circle_distance
// Haversine distance between two points given in fixed-point degrees.
//
// Input transfers on req_valid/req_ready carry two latitude/longitude pairs;
// each yields one rsp_distance_sixteenths_m transfer on rsp_valid/rsp_ready,
// in order. csr_write_enable loads the sphere radius in metres from
// csr_write_data; write it only while no item is in flight.
// Throughput: one item per cycle while the output is not stalled. The
// pipeline holds the two CORDIC chains (one register per iteration) and
// the 31-stage bit-per-cycle square root.
// Reset clears all valid bits and loads the radius with 6371000 m.
// When rsp_ready is low with a result waiting, the whole pipeline holds and
// req_ready drops; nothing in flight is lost or repeated.
// ----------------------------------------------------------------------------
module great_circle_distance (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [gcd_pkg::LAT_W-1:0]      req_lat_a,
   input  logic signed [gcd_pkg::LON_W-1:0]      req_lon_a,
   input  logic signed [gcd_pkg::LAT_W-1:0]      req_lat_b,
   input  logic signed [gcd_pkg::LON_W-1:0]      req_lon_b,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [gcd_pkg::DIST_W-1:0]            rsp_distance_sixteenths_m,
   input  logic                                  csr_write_enable,
   input  logic [gcd_pkg::RADIUS_W-1:0]          csr_write_data
);

   localparam int DW = gcd_pkg::DIFF_W;
   localparam int XW = gcd_pkg::XY_W;
   localparam int QW = gcd_pkg::Q_W;
   localparam int RW = gcd_pkg::RADIUS_W;
   localparam int CW = gcd_pkg::CANG_W;
   localparam int LW = gcd_pkg::CANG_LO_W;
   localparam int PW = CW + RW + 1;

   logic advance;
   logic rsp_valid_ff;
   logic [gcd_pkg::DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic [RW-1:0] radius_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= gcd_pkg::RADIUS_RESET;
      end else if (csr_write_enable) begin
         radius_ff <= csr_write_data;
      end
   end

   // input stage: widen and take differences
   logic t0_valid_ff;
   logic signed [DW-1:0] t0_lat_a_ff, t0_lat_b_ff, t0_dlat_ff, t0_dlon_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t0_valid_ff <= 1'b0;
      end else if (advance) begin
         t0_valid_ff <= req_valid;
      end
      if (advance) begin
         t0_lat_a_ff <= DW'(req_lat_a);
         t0_lat_b_ff <= DW'(req_lat_b);
         t0_dlat_ff  <= DW'(req_lat_b) - DW'(req_lat_a);
         t0_dlon_ff  <= DW'(req_lon_b) - DW'(req_lon_a);
      end
   end

   gcd_pkg::trig_type trig_a, trig_b, trig_dlat, trig_dlon;
   logic sc_valid;

   gcd_sincos u_sc_lat_a (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(t0_valid_ff),
      .half_angle(1'b0), .angle(t0_lat_a_ff), .out_valid(sc_valid), .trig(trig_a)
   );

   gcd_sincos u_sc_lat_b (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(t0_valid_ff),
      .half_angle(1'b0), .angle(t0_lat_b_ff), .out_valid(), .trig(trig_b)
   );

   gcd_sincos u_sc_dlat (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(t0_valid_ff),
      .half_angle(1'b1), .angle(t0_dlat_ff), .out_valid(), .trig(trig_dlat)
   );

   gcd_sincos u_sc_dlon (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(t0_valid_ff),
      .half_angle(1'b1), .angle(t0_dlon_ff), .out_valid(), .trig(trig_dlon)
   );

   // haversine stage 1: squares and cosine product
   logic signed [2*XW-1:0] hp_prod, hl_prod, cc_prod;
   logic signed [QW-1:0] m1_hp_ff, m1_hl_ff, m1_cc_ff;
   logic m1_valid_ff;

   assign hp_prod = (2*XW)'(trig_dlat.sine) * (2*XW)'(trig_dlat.sine);
   assign hl_prod = (2*XW)'(trig_dlon.sine) * (2*XW)'(trig_dlon.sine);
   assign cc_prod = (2*XW)'(trig_a.cosine) * (2*XW)'(trig_b.cosine);

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else if (advance) begin
         m1_valid_ff <= sc_valid;
      end
      if (advance) begin
         m1_hp_ff <= QW'(hp_prod >>> 30);
         m1_hl_ff <= QW'(hl_prod >>> 30);
         m1_cc_ff <= QW'(cc_prod >>> 30);
      end
   end

   // haversine stage 2: cosine product times longitude term
   logic signed [2*QW-1:0] t_prod;
   logic signed [QW-1:0] m2_hp_ff, m2_t_ff;
   logic m2_valid_ff;

   assign t_prod = (2*QW)'(m1_cc_ff) * (2*QW)'(m1_hl_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else if (advance) begin
         m2_valid_ff <= m1_valid_ff;
      end
      if (advance) begin
         m2_hp_ff <= m1_hp_ff;
         m2_t_ff  <= QW'(t_prod >>> 30);
      end
   end

   // haversine stage 3: sum, clamp to [0, 1], complement
   logic signed [QW:0] a_sum;
   logic [gcd_pkg::A_W-1:0] a_in, m3_a_ff, m3_b_ff;
   logic m3_valid_ff;

   always_comb begin
      a_sum = (QW+1)'(m2_hp_ff) + (QW+1)'(m2_t_ff);
      if (a_sum < 0) begin
         a_in = '0;
      end else if (a_sum > $signed((QW+1)'(gcd_pkg::ONE_Q30))) begin
         a_in = gcd_pkg::ONE_Q30;
      end else begin
         a_in = a_sum[gcd_pkg::A_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m3_valid_ff <= 1'b0;
      end else if (advance) begin
         m3_valid_ff <= m2_valid_ff;
      end
      if (advance) begin
         m3_a_ff <= a_in;
         m3_b_ff <= gcd_pkg::ONE_Q30 - a_in;
      end
   end

   logic [gcd_pkg::ROOT_W-1:0] root_a, root_b;
   logic sq_valid;

   gcd_isqrt u_sqrt_a (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(m3_valid_ff),
      .radicand(m3_a_ff), .out_valid(sq_valid), .root(root_a)
   );

   gcd_isqrt u_sqrt_b (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(m3_valid_ff),
      .radicand(m3_b_ff), .out_valid(), .root(root_b)
   );

   logic signed [gcd_pkg::ANG_W-1:0] half_angle;
   logic at_valid;

   gcd_atan2 u_atan2 (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(sq_valid),
      .y_val(root_a), .x_val(root_b), .out_valid(at_valid), .angle(half_angle)
   );

   // scale stage 1: central angle, clamp at zero
   logic [CW-1:0] f1_cang_ff;
   logic f1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else if (advance) begin
         f1_valid_ff <= at_valid;
      end
      if (advance) begin
         f1_cang_ff <= (half_angle < 0) ? '0 : (CW'(half_angle) << 1);
      end
   end

   // scale stage 2: partial products with the radius
   logic [LW+RW-1:0] f2_lo_ff;
   logic [CW-LW+RW-1:0] f2_hi_ff;
   logic f2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_valid_ff <= 1'b0;
      end else if (advance) begin
         f2_valid_ff <= f1_valid_ff;
      end
      if (advance) begin
         f2_lo_ff <= (LW+RW)'(f1_cang_ff[LW-1:0]) * (LW+RW)'(radius_ff);
         f2_hi_ff <= (CW-LW+RW)'(f1_cang_ff[CW-1:LW]) * (CW-LW+RW)'(radius_ff);
      end
   end

   // scale stage 3: sum, round half up, saturate
   logic [PW-1:0] dist_prod, dist_rnd;

   always_comb begin
      dist_prod = PW'(f2_lo_ff) + (PW'(f2_hi_ff) << LW);
      dist_rnd  = (dist_prod + (PW'(1) << 35)) >> 36;
      if (dist_rnd > PW'(gcd_pkg::DIST_MAX)) begin
         rsp_dist_in = gcd_pkg::DIST_MAX;
      end else begin
         rsp_dist_in = dist_rnd[gcd_pkg::DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= f2_valid_ff;
      end
      if (advance) begin
         rsp_dist_ff <= rsp_dist_in;
      end
   end

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_distance_sixteenths_m = rsp_dist_ff;

   a_plus_b_is_one : assert property (@(posedge clock) disable iff (reset)
      m3_valid_ff |-> (32'(m3_a_ff) + 32'(m3_b_ff) == 32'(gcd_pkg::ONE_Q30)))
      else $error("haversine term and complement do not sum to one");

   hold_on_stall : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(t0_valid_ff) && $stable(m3_valid_ff) && $stable(f2_valid_ff))
      else $error("pipeline moved while stalled");

   root_in_range : assert property (@(posedge clock) disable iff (reset)
      sq_valid |-> (root_a <= gcd_pkg::ROOT_W'(gcd_pkg::ONE_Q30)
                    && root_b <= gcd_pkg::ROOT_W'(gcd_pkg::ONE_Q30)))
      else $error("square root beyond one");

endmodule

### hdl/gcd_sincos.sv
// ----------------------------------------------------------------------------
// gcd_sincos
// Degrees to radians (halved if half_angle), range reduction and a
// rotation-mode CORDIC, one iteration per register stage; output registered.
// ----------------------------------------------------------------------------
module gcd_sincos (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                in_valid,
   input  logic                                half_angle,
   input  logic signed [gcd_pkg::DIFF_W-1:0]   angle,
   output logic                                out_valid,
   output gcd_pkg::trig_type                   trig
);

   localparam int N = gcd_pkg::CORDIC_STAGES;
   localparam int AW = gcd_pkg::ANG_W;
   localparam int XW = gcd_pkg::XY_W;
   localparam int PW = gcd_pkg::DIFF_W + gcd_pkg::DEG_LO_W + gcd_pkg::DEG_HI_W + 1;
   localparam int SH = gcd_pkg::TO_RAD_SHIFT;

   // stage 1: magnitude times split constant
   logic [gcd_pkg::DIFF_W-1:0] mag_in;
   logic [gcd_pkg::DIFF_W+gcd_pkg::DEG_LO_W-1:0] plo_in, plo_ff;
   logic [gcd_pkg::DIFF_W+gcd_pkg::DEG_HI_W-1:0] phi_in, phi_ff;
   logic s1_valid_ff, s1_neg_ff, s1_half_ff;

   assign mag_in = angle[gcd_pkg::DIFF_W-1] ? gcd_pkg::DIFF_W'(-angle)
                                            : gcd_pkg::DIFF_W'(angle);
   assign plo_in = (gcd_pkg::DIFF_W+gcd_pkg::DEG_LO_W)'(mag_in)
                 * (gcd_pkg::DIFF_W+gcd_pkg::DEG_LO_W)'(gcd_pkg::DEG2RAD_LO);
   assign phi_in = (gcd_pkg::DIFF_W+gcd_pkg::DEG_HI_W)'(mag_in)
                 * (gcd_pkg::DIFF_W+gcd_pkg::DEG_HI_W)'(gcd_pkg::DEG2RAD_HI);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
      end
      if (advance) begin
         plo_ff     <= plo_in;
         phi_ff     <= phi_in;
         s1_neg_ff  <= angle[gcd_pkg::DIFF_W-1];
         s1_half_ff <= half_angle;
      end
   end

   // stage 2: sum, round half away from zero, restore sign
   logic [PW-1:0] prod;
   logic [PW-1:0] rnd;
   logic signed [AW-1:0] ang_in, ang_ff;
   logic s2_valid_ff;

   always_comb begin
      prod = PW'(plo_ff) + (PW'(phi_ff) << gcd_pkg::DEG_LO_W);
      if (s1_half_ff) begin
         rnd = (prod + (PW'(1) << SH)) >> (SH + 1);
      end else begin
         rnd = (prod + (PW'(1) << (SH - 1))) >> SH;
      end
      ang_in = s1_neg_ff ? -$signed(rnd[AW-1:0]) : $signed(rnd[AW-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         ang_ff <= ang_in;
      end
   end

   // stage 3: modulo two pi
   logic signed [AW-1:0] mod_in, mod_ff;
   logic s3_valid_ff;

   always_comb begin
      if (ang_ff >= gcd_pkg::TWO_PI_Q40) begin
         mod_in = ang_ff - gcd_pkg::TWO_PI_Q40;
      end else if (ang_ff <= -gcd_pkg::TWO_PI_Q40) begin
         mod_in = ang_ff + gcd_pkg::TWO_PI_Q40;
      end else begin
         mod_in = ang_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (advance) begin
         mod_ff <= mod_in;
      end
   end

   // stage 4: wrap into [-pi, pi]
   logic signed [AW-1:0] wrap_in, wrap_ff;
   logic s4_valid_ff;

   always_comb begin
      if (mod_ff > gcd_pkg::PI_Q40) begin
         wrap_in = mod_ff - gcd_pkg::TWO_PI_Q40;
      end else if (mod_ff < -gcd_pkg::PI_Q40) begin
         wrap_in = mod_ff + gcd_pkg::TWO_PI_Q40;
      end else begin
         wrap_in = mod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (advance) begin
         wrap_ff <= wrap_in;
      end
   end

   // stage 5: fold into [-pi/2, pi/2]
   logic signed [AW-1:0] fold_in, fold_ff;
   logic flip_in, flip_ff;
   logic s5_valid_ff;

   always_comb begin
      flip_in = 1'b0;
      fold_in = wrap_ff;
      if (wrap_ff > gcd_pkg::HALF_PI_Q40) begin
         fold_in = gcd_pkg::PI_Q40 - wrap_ff;
         flip_in = 1'b1;
      end else if (wrap_ff < -gcd_pkg::HALF_PI_Q40) begin
         fold_in = -gcd_pkg::PI_Q40 - wrap_ff;
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s5_valid_ff <= s4_valid_ff;
      end
      if (advance) begin
         fold_ff <= fold_in;
         flip_ff <= flip_in;
      end
   end

   // CORDIC iterations
   logic signed [XW-1:0] cx_ff [N];
   logic signed [XW-1:0] cy_ff [N];
   logic signed [AW-1:0] cr_ff [N];
   logic                 cf_ff [N];
   logic                 cv_ff [N];

   for (genvar i = 0; i < N; i++) begin : g_iter
      localparam logic signed [AW-1:0] ATAN_STEP = gcd_pkg::atan_q40(i);
      logic signed [XW-1:0] x_prev, y_prev, x_in, y_in;
      logic signed [AW-1:0] r_prev, r_in;
      logic f_prev, v_prev;

      if (i == 0) begin : g_first
         assign x_prev = gcd_pkg::GAIN_Q30;
         assign y_prev = '0;
         assign r_prev = fold_ff;
         assign f_prev = flip_ff;
         assign v_prev = s5_valid_ff;
      end else begin : g_next
         assign x_prev = cx_ff[i-1];
         assign y_prev = cy_ff[i-1];
         assign r_prev = cr_ff[i-1];
         assign f_prev = cf_ff[i-1];
         assign v_prev = cv_ff[i-1];
      end

      always_comb begin
         if (r_prev >= 0) begin
            x_in = x_prev - (y_prev >>> i);
            y_in = y_prev + (x_prev >>> i);
            r_in = r_prev - ATAN_STEP;
         end else begin
            x_in = x_prev + (y_prev >>> i);
            y_in = y_prev - (x_prev >>> i);
            r_in = r_prev + ATAN_STEP;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[i] <= 1'b0;
         end else if (advance) begin
            cv_ff[i] <= v_prev;
         end
         if (advance) begin
            cx_ff[i] <= x_in;
            cy_ff[i] <= y_in;
            cr_ff[i] <= r_in;
            cf_ff[i] <= f_prev;
         end
      end
   end

   // output register
   gcd_pkg::trig_type trig_in, trig_ff;
   logic out_valid_ff;

   always_comb begin
      trig_in.sine   = cy_ff[N-1];
      trig_in.cosine = cf_ff[N-1] ? -cx_ff[N-1] : cx_ff[N-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= cv_ff[N-1];
      end
      if (advance) begin
         trig_ff <= trig_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign trig      = trig_ff;

endmodule

### hdl/gcd_isqrt.sv
// ----------------------------------------------------------------------------
// gcd_isqrt
// Floor square root of radicand * 2^30, one root bit per register stage.
// ----------------------------------------------------------------------------
module gcd_isqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           in_valid,
   input  logic [gcd_pkg::A_W-1:0]        radicand,
   output logic                           out_valid,
   output logic [gcd_pkg::ROOT_W-1:0]     root
);

   localparam int N  = gcd_pkg::SQRT_STAGES;
   localparam int RW = gcd_pkg::ROOT_W;
   localparam int MW = RW + 2;
   localparam int VW = 2 * N;

   logic [MW-1:0] rem_ff  [N];
   logic [RW-1:0] root_ff [N];
   logic [VW-1:0] v_ff    [N];
   logic          val_ff  [N];

   for (genvar k = 0; k < N; k++) begin : g_step
      logic [MW-1:0] rem_prev, rem_in;
      logic [RW-1:0] root_prev, root_in;
      logic [VW-1:0] v_prev;
      logic [MW+1:0] rem_sh, trial;
      logic          v_ok;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign v_prev    = VW'({radicand, 30'b0});
         assign v_ok      = in_valid;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign v_prev    = v_ff[k-1];
         assign v_ok      = val_ff[k-1];
      end

      always_comb begin
         rem_sh = {rem_prev, v_prev[VW-1:VW-2]};
         trial  = (MW+2)'({root_prev, 2'b01});
         if (rem_sh >= trial) begin
            rem_in  = MW'(rem_sh - trial);
            root_in = {root_prev[RW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[MW-1:0];
            root_in = {root_prev[RW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[k] <= 1'b0;
         end else if (advance) begin
            val_ff[k] <= v_ok;
         end
         if (advance) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            v_ff[k]    <= v_prev << 2;
         end
      end
   end

   assign out_valid = val_ff[N-1];
   assign root      = root_ff[N-1];

endmodule

### hdl/gcd_atan2.sv
// ----------------------------------------------------------------------------
// gcd_atan2
// Vectoring-mode CORDIC for atan2(y, x) with x, y >= 0, one iteration per
// register stage.
// ----------------------------------------------------------------------------
module gcd_atan2 (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                in_valid,
   input  logic [gcd_pkg::ROOT_W-1:0]          y_val,
   input  logic [gcd_pkg::ROOT_W-1:0]          x_val,
   output logic                                out_valid,
   output logic signed [gcd_pkg::ANG_W-1:0]    angle
);

   localparam int N  = gcd_pkg::CORDIC_STAGES;
   localparam int XW = gcd_pkg::ATAN2_W;
   localparam int AW = gcd_pkg::ANG_W;

   logic signed [XW-1:0] vx_ff [N];
   logic signed [XW-1:0] vy_ff [N];
   logic signed [AW-1:0] vz_ff [N];
   logic                 vv_ff [N];

   for (genvar i = 0; i < N; i++) begin : g_iter
      localparam logic signed [AW-1:0] ATAN_STEP = gcd_pkg::atan_q40(i);
      logic signed [XW-1:0] x_prev, y_prev, x_in, y_in;
      logic signed [AW-1:0] z_prev, z_in;
      logic v_prev;

      if (i == 0) begin : g_first
         assign x_prev = $signed(XW'(x_val));
         assign y_prev = $signed(XW'(y_val));
         assign z_prev = '0;
         assign v_prev = in_valid;
      end else begin : g_next
         assign x_prev = vx_ff[i-1];
         assign y_prev = vy_ff[i-1];
         assign z_prev = vz_ff[i-1];
         assign v_prev = vv_ff[i-1];
      end

      always_comb begin
         if (y_prev > 0) begin
            x_in = x_prev + (y_prev >>> i);
            y_in = y_prev - (x_prev >>> i);
            z_in = z_prev + ATAN_STEP;
         end else begin
            x_in = x_prev - (y_prev >>> i);
            y_in = y_prev + (x_prev >>> i);
            z_in = z_prev - ATAN_STEP;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vv_ff[i] <= 1'b0;
         end else if (advance) begin
            vv_ff[i] <= v_prev;
         end
         if (advance) begin
            vx_ff[i] <= x_in;
            vy_ff[i] <= y_in;
            vz_ff[i] <= z_in;
         end
      end
   end

   assign out_valid = vv_ff[N-1];
   assign angle     = vz_ff[N-1];

endmodule

### tb/sv/gcd_distance_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gcd_distance_checker
// Watches the request, response and radius ports of the great-circle distance
// block, works out the haversine distance of every accepted request in fixed
// point and compares each response with the oldest pending distance.
// ----------------------------------------------------------------------------
module gcd_distance_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic signed [gcd_pkg::LAT_W-1:0]      req_lat_a,
   input  logic signed [gcd_pkg::LON_W-1:0]      req_lon_a,
   input  logic signed [gcd_pkg::LAT_W-1:0]      req_lat_b,
   input  logic signed [gcd_pkg::LON_W-1:0]      req_lon_b,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic [gcd_pkg::DIST_W-1:0]            rsp_distance_sixteenths_m,
   input  logic                                  csr_write_enable,
   input  logic [gcd_pkg::RADIUS_W-1:0]          csr_write_data,
   output int                                    mismatch_count,
   output int                                    pending_count,
   output int                                    compared_count
);

   localparam logic [63:0] PI_Q60_K    = 64'h3243F6A8885A308D;
   localparam longint      UNIT_Q30    = 64'sd1 << 30;
   localparam longint      GAIN_K      = 64'sh26DD3B6A;
   localparam int          STAGES      = gcd_pkg::CORDIC_STAGES;

   longint                          arctan_q40 [0:31];
   longint                          pi_k, two_pi_k, half_pi_k;
   logic [63:0]                     deg_to_rad_q62;
   logic [gcd_pkg::RADIUS_W-1:0]    radius_m;
   logic [gcd_pkg::DIST_W-1:0]      distance_queue [$];

   initial begin
      longint acc;
      longint term;
      arctan_q40[0] = longint'((PI_Q60_K + 64'd2097152) >> 22);
      for (int i = 1; i < 32; i++) begin
         acc = 0;
         for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
            term = longint'((64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1));
            acc = k[0] ? acc - term : acc + term;
         end
         arctan_q40[i] = (acc + 64'sd2097152) >>> 22;
      end
      pi_k = longint'((PI_Q60_K + 64'd524288) >> 20);
      two_pi_k = 2 * pi_k;
      half_pi_k = pi_k / 2;
      deg_to_rad_q62 = PI_Q60_K / 64'd45;
   end

   function automatic longint degrees_to_radians(input longint deg, input int extra);
      logic [63:0]  mag;
      logic [127:0] prod;
      int           sh;
      longint       rad;
      mag = deg < 0 ? 64'(-deg) : 64'(deg);
      sh = 44 + extra;
      prod = 128'(mag) * 128'(deg_to_rad_q62) + (128'd1 << (sh - 1));
      rad = longint'(prod >> sh);
      return deg < 0 ? -rad : rad;
   endfunction

   task automatic rotate_sin_cos(input longint ang, output longint s, output longint c);
      longint r, x, y, dx, dy;
      bit     flip;
      r = ang % two_pi_k;
      x = GAIN_K;
      y = 0;
      flip = 0;
      if (r > pi_k) r -= two_pi_k;
      if (r < -pi_k) r += two_pi_k;
      if (r > half_pi_k) begin
         r = pi_k - r;
         flip = 1;
      end else if (r < -half_pi_k) begin
         r = -pi_k - r;
         flip = 1;
      end
      for (int i = 0; i < STAGES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (r >= 0) begin
            x -= dx; y += dy; r -= arctan_q40[i];
         end else begin
            x += dx; y -= dy; r += arctan_q40[i];
         end
      end
      s = y;
      c = flip ? -x : x;
   endtask

   function automatic longint vector_angle(input longint y0, input longint x0);
      longint x, y, z, dx, dy;
      x = x0;
      y = y0;
      z = 0;
      for (int i = 0; i < STAGES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; z += arctan_q40[i];
         end else begin
            x -= dx; y += dy; z -= arctan_q40[i];
         end
      end
      return z;
   endfunction

   function automatic logic [63:0] floor_root(input logic [63:0] v0);
      logic [63:0] v, r, b;
      v = v0;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   task automatic haversine_distance(input longint lat_a, input longint lon_a,
                                     input longint lat_b, input longint lon_b,
                                     input logic [gcd_pkg::RADIUS_W-1:0] radius,
                                     output logic [gcd_pkg::DIST_W-1:0] dist_out);
      longint       s1, c1, s2, c2, sp, cp, sl, cl, hp, hl, cc, a, z, cang;
      logic [63:0]  sa, sb;
      logic [127:0] prod;
      rotate_sin_cos(degrees_to_radians(lat_a, 0), s1, c1);
      rotate_sin_cos(degrees_to_radians(lat_b, 0), s2, c2);
      rotate_sin_cos(degrees_to_radians(lat_b - lat_a, 1), sp, cp);
      rotate_sin_cos(degrees_to_radians(lon_b - lon_a, 1), sl, cl);
      hp = (sp * sp) >>> 30;
      hl = (sl * sl) >>> 30;
      cc = (c1 * c2) >>> 30;
      a = hp + ((cc * hl) >>> 30);
      if (a < 0) a = 0;
      if (a > UNIT_Q30) a = UNIT_Q30;
      sa = floor_root(64'(a) << 30);
      sb = floor_root(64'(UNIT_Q30 - a) << 30);
      z = vector_angle(longint'(sa), longint'(sb));
      cang = 2 * z;
      if (cang < 0) cang = 0;
      if (radius == 0) begin
         dist_out = '0;
      end else begin
         prod = (128'(cang) * 128'(radius) + (128'd1 << 35)) >> 36;
         dist_out = (prod > 128'(gcd_pkg::DIST_MAX)) ? gcd_pkg::DIST_MAX
                                                     : gcd_pkg::DIST_W'(prod);
      end
   endtask

   assign pending_count = distance_queue.size();

   always @(posedge clock) begin
      logic [gcd_pkg::DIST_W-1:0] want;
      if (reset) begin
         radius_m <= gcd_pkg::RADIUS_RESET;
         distance_queue.delete();
         mismatch_count <= 0;
         compared_count <= 0;
      end else begin
         if (req_valid && req_ready) begin
            haversine_distance(req_lat_a, req_lon_a, req_lat_b, req_lon_b, radius_m, want);
            distance_queue = {distance_queue, want};
         end
         if (rsp_valid && rsp_ready) begin
            compared_count <= compared_count + 1;
            if (distance_queue.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected distance transfer: got %0d", rsp_distance_sixteenths_m);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = distance_queue.pop_front();
               if (want !== rsp_distance_sixteenths_m) begin
                  if (mismatch_count < 10)
                     $display("distance mismatch: expected %0d got %0d",
                              want, rsp_distance_sixteenths_m);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (csr_write_enable)
            radius_m <= csr_write_data;
      end
   end

endmodule

### tb/sv/tb_great_circle_distance.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_great_circle_distance
// Drives point pairs into the great-circle distance block over several sphere
// radii and idle patterns, including a long response hold-off; the checker
// beside the block predicts and compares every distance.
// ----------------------------------------------------------------------------
module tb_great_circle_distance;

   localparam int     LAT_LIM    = 377487360;
   localparam int     LON_LIM    = 754974720;
   localparam int     DEG        = 4194304;
   localparam int     CYCLE_LIMIT = 300000;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_ready;
   logic signed [gcd_pkg::LAT_W-1:0]     req_lat_a;
   logic signed [gcd_pkg::LON_W-1:0]     req_lon_a;
   logic signed [gcd_pkg::LAT_W-1:0]     req_lat_b;
   logic signed [gcd_pkg::LON_W-1:0]     req_lon_b;
   logic                                 rsp_valid;
   logic                                 rsp_ready;
   logic [gcd_pkg::DIST_W-1:0]           rsp_distance_sixteenths_m;
   logic                                 csr_write_enable;
   logic [gcd_pkg::RADIUS_W-1:0]         csr_write_data;

   int  mismatch_count, pending_count, compared_count;
   int  sent_count, received_count, cycle_count;
   int  send_idle_pct, recv_idle_pct;
   int  hold_request, hold_left;

   great_circle_distance dut (.*);

   gcd_distance_checker checker_0 (.*);

   initial begin
      clock = 0;
   end
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         received_count <= received_count + 1;
   end

   // receiver: random stalls, plus a long hold-off when requested
   always @(posedge clock) begin
      if (hold_request != 0 && hold_left == 0) begin
         hold_left <= hold_request;
         hold_request <= 0;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= (hold_left == 1);
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_pair(input int lat_a, input int lon_a, input int lat_b, input int lon_b);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_lat_a <= gcd_pkg::LAT_W'(lat_a);
      req_lon_a <= gcd_pkg::LON_W'(lon_a);
      req_lat_b <= gcd_pkg::LAT_W'(lat_b);
      req_lon_b <= gcd_pkg::LON_W'(lon_b);
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   function automatic int clip(input int v, input int lim);
      return v > lim ? lim : (v < -lim ? -lim : v);
   endfunction

   function automatic int pick(input int lim);
      return int'($urandom_range(0, 2 * lim)) - lim;
   endfunction

   task automatic send_random_pair();
      int la, oa, lb, ob, d;
      la = pick(LAT_LIM);
      oa = pick(LON_LIM);
      lb = pick(LAT_LIM);
      ob = pick(LON_LIM);
      case ($urandom_range(9))
         4, 5: begin
            d = int'($urandom_range(0, 1 << ($urandom_range(2, 24)))) ;
            lb = clip(la + ($urandom_range(1) ? d : -d), LAT_LIM);
            ob = clip(oa + pick(d), LON_LIM);
         end
         6: begin
            lb = la;
            ob = oa;
         end
         7: begin
            lb = -la;
            ob = oa > 0 ? oa - 180 * DEG : oa + 180 * DEG;
            ob = clip(ob + pick(64), LON_LIM);
         end
         8: begin
            la = $urandom_range(1) ? LAT_LIM : -LAT_LIM;
            lb = $urandom_range(2) == 0 ? 0 : ($urandom_range(1) ? LAT_LIM : -LAT_LIM);
            oa = $urandom_range(1) ? LON_LIM : -LON_LIM;
         end
         9: begin
            la = 90 * DEG;
            lb = -90 * DEG + pick(1000);
         end
         default: ;
      endcase
      send_pair(la, oa, lb, ob);
   endtask

   task automatic drain_and_write(input logic [gcd_pkg::RADIUS_W-1:0] radius);
      req_valid <= 1'b0;
      while (received_count != sent_count) @(posedge clock);
      repeat (100) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= radius;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_lat_a = '0;
      req_lon_a = '0;
      req_lat_b = '0;
      req_lon_b = '0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      sent_count = 0;
      received_count = 0;
      cycle_count = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request = 0;
      hold_left = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed pairs at the reset radius
      send_pair(0, 0, 0, 0);
      send_pair(LAT_LIM, LON_LIM, LAT_LIM, LON_LIM);
      send_pair(LAT_LIM, LON_LIM, -LAT_LIM, -LON_LIM);
      send_pair(-LAT_LIM, -LON_LIM, LAT_LIM, LON_LIM);
      send_pair(0, 0, 0, 180 * DEG);
      send_pair(0, -90 * DEG, 0, 90 * DEG);
      send_pair(90 * DEG, 0, -90 * DEG, 0);
      send_pair(-90 * DEG, 17 * DEG, 90 * DEG, -123 * DEG);
      send_pair(0, 180 * DEG - 1, 0, -180 * DEG + 1);
      send_pair(45 * DEG, LON_LIM, 45 * DEG, -LON_LIM);
      send_pair(1, 1, 0, 0);
      send_pair(-1, -1, 0, 0);
      send_pair(48 * DEG, 2 * DEG, 48 * DEG + 7, 2 * DEG - 3);
      send_pair(30 * DEG, 10 * DEG, -30 * DEG, -170 * DEG);
      send_pair(LAT_LIM, 0, LAT_LIM - 1, LON_LIM);
      send_pair(-LAT_LIM, LON_LIM, -LAT_LIM, -LON_LIM);
      send_pair(12345678, -87654321, 12345678, -87654321);
      send_pair(1, LON_LIM, -1, -LON_LIM);

      drain_and_write(23'd6000000);
      send_idle_pct = 25;
      recv_idle_pct = 51;
      repeat (500) send_random_pair();

      drain_and_write(23'd7000000);
      send_idle_pct = 51;
      recv_idle_pct = 25;
      repeat (500) send_random_pair();

      // zero radius, then the largest radius the register holds
      drain_and_write('0);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (40) send_random_pair();
      drain_and_write({gcd_pkg::RADIUS_W{1'b1}});
      send_pair(0, 0, 0, 180 * DEG);
      send_pair(90 * DEG, 0, -90 * DEG, 0);
      repeat (40) send_random_pair();

      drain_and_write(gcd_pkg::RADIUS_RESET);
      hold_request = 400;
      repeat (450) send_random_pair();

      req_valid <= 1'b0;
      while (received_count != sent_count) @(posedge clock);
      repeat (150) @(posedge clock);

      $display("%0d point pairs sent, %0d distances compared", sent_count, compared_count);
      $display("radii: reset, 6000000, 7000000, zero, full scale; with idling and a long stall");
      if (mismatch_count == 0 && pending_count == 0 && received_count == sent_count) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
